// File: design/formation_point_generator_macros.svh
// Assertion macros for the formation point generator checker.
`ifndef FORMATION_POINT_GENERATOR_MACROS_SVH
`define FORMATION_POINT_GENERATOR_MACROS_SVH
// Antecedent implies consequent on the next clock.
`define FPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
// Antecedent implies consequent on the same clock.
`define FPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`endif

// File: design/fpg_pkg.sv
// ---------------------------------------------------------------------------
// fpg_pkg
// Shared types and constants of the formation point generator.
// ---------------------------------------------------------------------------
package fpg_pkg;

  localparam int CoordW = 17;
  localparam logic signed [CoordW-1:0] CoordMax = 17'sd65535;

  // Largest point count; the count register is 11 bits wide to hold it.
  localparam int MaxPoints = 1024;

  typedef enum logic [1:0] {
    SHAPE_CIRCLE = 2'd0,
    SHAPE_TRI    = 2'd1,
    SHAPE_RECT   = 2'd2,
    SHAPE_NONE   = 2'd3
  } shape_t;

  localparam logic [2:0] REG_SHAPE  = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd1;
  localparam logic [2:0] REG_RADIUS = 3'd2;
  localparam logic [2:0] REG_SIDE   = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  localparam logic [63:0] HalfPiQ30  = 64'h6487ED51;
  localparam logic [63:0] CordicKQ30 = 64'h26DD3B6A;
  localparam logic [63:0] Sqrt3Q16   = 64'd56756;

  typedef struct packed {
    shape_t      shape;
    logic [15:0] radius;
    logic [15:0] side;
    logic [15:0] width;
    logic [15:0] height;
  } cfg_t;

  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] t [24];
    t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
          32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
          32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
          32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
          32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F};
    return t[i];
  endfunction

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [63:0] v);
    logic signed [CoordW-1:0] r;
    if (v > 64'sd65535) r = CoordMax;
    else if (v < -64'sd65535) r = -CoordMax;
    else r = v[CoordW-1:0];
    return r;
  endfunction

endpackage

// File: design/fpg_stream_if.sv
// ---------------------------------------------------------------------------
// fpg_stream_if
// Valid/ready channel carrying one beat of payload.
// ---------------------------------------------------------------------------
interface fpg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/fpg_divider.sv
// ---------------------------------------------------------------------------
// fpg_divider
// Pipelined restoring divider: one quotient bit per stage.
// ---------------------------------------------------------------------------
module fpg_divider #(
  parameter int NumW = 26,
  parameter int DenW = 17,
  parameter int TagW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  input  logic [TagW-1:0] in_tag,
  output logic            out_valid,
  output logic [NumW-1:0] quot,
  output logic [TagW-1:0] out_tag
);
  logic            v   [NumW+1];
  logic [NumW-1:0] q   [NumW+1];
  logic [DenW:0]   rem [NumW+1];
  logic [DenW-1:0] d   [NumW+1];
  logic [TagW-1:0] tg  [NumW+1];

  assign v[0]   = in_valid;
  assign q[0]   = num;
  assign rem[0] = '0;
  assign d[0]   = den;
  assign tg[0]  = in_tag;

  for (genvar k = 0; k < NumW; k++) begin : g_st
    logic [DenW+1:0] trial;
    logic [DenW:0]   shifted;
    assign shifted = {rem[k][DenW-1:0], q[k][NumW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, d[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= trial[DenW+1] ? shifted : trial[DenW:0];
        q[k+1]   <= {q[k][NumW-2:0], ~trial[DenW+1]};
        d[k+1]   <= d[k];
        tg[k+1]  <= tg[k];
      end
    end
  end

  assign out_valid = v[NumW];
  assign quot      = q[NumW];
  assign out_tag   = tg[NumW];
endmodule

// File: design/fpg_cordic.sv
// ---------------------------------------------------------------------------
// fpg_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage.
// ---------------------------------------------------------------------------
module fpg_cordic #(
  parameter int Stages = 16,
  parameter int TagW   = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [47:0] x_in,
  input  logic signed [47:0] z_in,
  input  logic [TagW-1:0]    in_tag,
  output logic               out_valid,
  output logic signed [47:0] x_out,
  output logic signed [47:0] y_out,
  output logic [TagW-1:0]    out_tag
);
  logic               v  [Stages+1];
  logic signed [47:0] x  [Stages+1];
  logic signed [47:0] y  [Stages+1];
  logic signed [47:0] z  [Stages+1];
  logic [TagW-1:0]    tg [Stages+1];

  assign v[0]  = in_valid;
  assign x[0]  = x_in;
  assign y[0]  = '0;
  assign z[0]  = z_in;
  assign tg[0] = in_tag;

  for (genvar i = 0; i < Stages; i++) begin : g_st
    logic signed [47:0] dx, dy, at;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;
    assign at = {16'd0, fpg_pkg::atan_q30(i)};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        tg[i+1] <= tg[i];
        if (!z[i][47]) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - at;
        end else begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + at;
        end
      end
    end
  end

  assign out_valid = v[Stages];
  assign x_out     = x[Stages];
  assign y_out     = y[Stages];
  assign out_tag   = tg[Stages];
endmodule

// File: design/formation_point_generator.sv
// ---------------------------------------------------------------------------
// formation_point_generator
// Places point index/count evenly along a circle, triangle or rectangle.
// ---------------------------------------------------------------------------
// Channel   Direction  Payload
// in_ch     sink       point_index
// out_ch    source     x_pos, y_pos, out_of_range
// apb       slave      six config registers at 4*i
//
// One index enters per cycle and one point leaves per cycle once the pipe
// is primed and the output is not stalled. Every item passes 10 +
// PHASE_BITS divider stages, CORDIC_STAGES rotation stages and the output
// register: 43 register stages at the defaults. The polygon math takes a
// setup stage plus a delay line beside the CORDIC and keeps in step with
// it. Every stage advances only when the output register is free, so a
// stall holds the whole pipe and drops nothing.
// Reset clears valid bits and restores register defaults.
// ---------------------------------------------------------------------------
module formation_point_generator #(
  parameter int PHASE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  fpg_stream_if.sink   in_ch,
  fpg_stream_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int NumW = 10 + PHASE_BITS;
  localparam int TagW = 3;

  // ---- configuration registers ----
  fpg_pkg::cfg_t cfg;
  logic [10:0]   point_count;
  logic [2:0]    reg_idx;
  logic [10:0]   wcount;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  // Saturate the low 11 bits of a count at the largest supported count.
  assign wcount  = (pwdata[10:0] > 11'(fpg_pkg::MaxPoints)) ? 11'(fpg_pkg::MaxPoints)
                                                            : pwdata[10:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shape   <= fpg_pkg::SHAPE_CIRCLE;
      point_count <= 11'd10;
      cfg.radius  <= 16'd1280;
      cfg.side    <= 16'd2560;
      cfg.width   <= 16'd3072;
      cfg.height  <= 16'd1536;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        fpg_pkg::REG_SHAPE:  cfg.shape   <= fpg_pkg::shape_t'(pwdata[1:0]);
        fpg_pkg::REG_COUNT:  point_count <= wcount;
        fpg_pkg::REG_RADIUS: cfg.radius  <= pwdata[15:0];
        fpg_pkg::REG_SIDE:   cfg.side    <= pwdata[15:0];
        fpg_pkg::REG_WIDTH:  cfg.width   <= pwdata[15:0];
        fpg_pkg::REG_HEIGHT: cfg.height  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      fpg_pkg::REG_SHAPE:  prdata = {30'd0, cfg.shape};
      fpg_pkg::REG_COUNT:  prdata = {21'd0, point_count};
      fpg_pkg::REG_RADIUS: prdata = {16'd0, cfg.radius};
      fpg_pkg::REG_SIDE:   prdata = {16'd0, cfg.side};
      fpg_pkg::REG_WIDTH:  prdata = {16'd0, cfg.width};
      fpg_pkg::REG_HEIGHT: prdata = {16'd0, cfg.height};
      default:             prdata = '0;
    endcase
  end

  // Side length times sqrt(3)/2, refreshed from the register every cycle;
  // the user must change the register only with the pipe empty; not enforced.
  logic [63:0] side_k;
  always_ff @(posedge clk) begin
    side_k <= {48'd0, cfg.side} * fpg_pkg::Sqrt3Q16;
  end

  // ---- pipeline advance: move everything when the output slot frees ----
  logic adv;
  logic out_valid;
  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  // ---- stage 0: range check, feed the phase divider ----
  logic in_oor;
  assign in_oor = (point_count == 11'd0) || ({1'b0, in_ch.data} >= point_count);

  logic [NumW-1:0] div_num;
  logic [NumW-1:0] phase_full;
  logic [TagW-1:0] div_tag;
  logic            div_valid;
  assign div_num = {in_ch.data, PHASE_BITS'(0)};

  fpg_divider #(.NumW(NumW), .DenW(11), .TagW(TagW)) u_div (
    .clk, .rst, .adv,
    .in_valid (in_ch.valid && adv),
    .num      (div_num),
    .den      (point_count),
    .in_tag   ({in_oor, cfg.shape}),
    .out_valid(div_valid),
    .quot     (phase_full),
    .out_tag  (div_tag)
  );

  // ---- stage 1: angle setup for CORDIC, polygon products ----
  logic [PHASE_BITS-1:0] p;
  logic [31:0]           turn;
  logic [63:0]           zprod;
  logic signed [47:0]    cz, cx;
  assign p     = phase_full[PHASE_BITS-1:0];
  assign turn  = {p, (32 - PHASE_BITS)'(0)};
  assign zprod = {34'd0, turn[29:0]} * fpg_pkg::HalfPiQ30;
  assign cz    = 48'(zprod >> 30);
  assign cx    = 48'(({48'd0, cfg.radius} * fpg_pkg::CordicKQ30) >> 16);

  // Polygon side selection and scaled fraction, registered ahead of the CORDIC.
  logic                  s1_valid;
  logic [1:0]            s1_seg;
  logic [PHASE_BITS-1:0] s1_f;
  logic [33:0]           s1_d;
  logic [1:0]            s1_quad;
  logic [PHASE_BITS+1:0] u;
  logic [17:0]           perim;
  assign u     = {1'b0, p, 1'b0} + {2'b00, p};
  assign perim = {cfg.width, 1'b0} + {cfg.height, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv) s1_valid <= div_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_seg  <= u[PHASE_BITS+1:PHASE_BITS];
      s1_f    <= u[PHASE_BITS-1:0];
      s1_d    <= 34'(({16'd0, perim} * {18'd0, p}) >> PHASE_BITS);
      s1_quad <= turn[31:30];
    end
  end

  // ---- CORDIC for the circle; polygon path travels alongside ----
  logic               c_valid;
  logic signed [47:0] c_x, c_y;
  logic [TagW-1:0]    c_tag;
  fpg_cordic #(.Stages(CORDIC_STAGES), .TagW(TagW)) u_cordic (
    .clk, .rst, .adv,
    .in_valid (div_valid),
    .x_in     (cx),
    .z_in     (cz),
    .in_tag   (div_tag),
    .out_valid(c_valid),
    .x_out    (c_x),
    .y_out    (c_y),
    .out_tag  (c_tag)
  );

  // Polygon results, computed in stage 2 then delayed to match the CORDIC.
  logic signed [63:0] tri_x, tri_y, rx, ry;
  logic [63:0] s, f, g;
  logic signed [63:0] d, w, h;
  always_comb begin
    s  = {48'd0, cfg.side};
    f  = {{(64-PHASE_BITS){1'b0}}, s1_f};
    g  = (64'd1 << PHASE_BITS) - f;
    unique case (s1_seg)
      2'd0: begin
        tri_x = 64'((s * f + (64'd1 << (PHASE_BITS - 1))) >> PHASE_BITS);
        tri_y = '0;
      end
      2'd1: begin
        tri_x = 64'(s - ((s * f + (64'd1 << PHASE_BITS)) >> (PHASE_BITS + 1)));
        tri_y = 64'((side_k * f + (64'd1 << (PHASE_BITS + 15))) >> (PHASE_BITS + 16));
      end
      default: begin
        tri_x = 64'((s * g + (64'd1 << PHASE_BITS)) >> (PHASE_BITS + 1));
        tri_y = 64'((side_k * g + (64'd1 << (PHASE_BITS + 15))) >> (PHASE_BITS + 16));
      end
    endcase
    d = {30'd0, s1_d};
    w = {48'd0, cfg.width};
    h = {48'd0, cfg.height};
    priority if (d < w) begin
      rx = d;  ry = '0;
    end else if (d < w + h) begin
      rx = w;  ry = d - w;
    end else if (d < 2 * w + h) begin
      rx = w - (d - (w + h));  ry = h;
    end else begin
      rx = '0; ry = h - (d - (2 * w + h));
    end
  end

  localparam int Dly = CORDIC_STAGES - 1;
  typedef struct packed {
    logic [1:0]                quad;
    logic signed [16:0]        tx, ty, rx, ry;
  } side_t;
  side_t sd [Dly+1];
  assign sd[0] = '{s1_quad, fpg_pkg::sat_coord(tri_x), fpg_pkg::sat_coord(tri_y),
                   fpg_pkg::sat_coord(rx), fpg_pkg::sat_coord(ry)};
  for (genvar k = 0; k < Dly; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) sd[k+1] <= sd[k];
    end
  end

  // ---- final select and output register ----
  logic signed [63:0] cc, cs, ox, oy;
  side_t fin;
  assign fin = sd[Dly];
  always_comb begin
    cc = 64'(($signed(c_x) + 48'sd8192) >>> 14);
    cs = 64'(($signed(c_y) + 48'sd8192) >>> 14);
    unique case (fin.quad)
      2'd0:    begin ox = cc;  oy = cs;  end
      2'd1:    begin ox = -cs; oy = cc;  end
      2'd2:    begin ox = -cc; oy = -cs; end
      default: begin ox = cs;  oy = -cc; end
    endcase
  end

  logic signed [16:0] x_reg, y_reg;
  logic               oor_reg;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= c_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      oor_reg <= c_tag[2];
      if (c_tag[2]) begin
        x_reg <= '0; y_reg <= '0;
      end else begin
        unique case (fpg_pkg::shape_t'(c_tag[1:0]))
          fpg_pkg::SHAPE_CIRCLE: begin
            x_reg <= fpg_pkg::sat_coord(ox); y_reg <= fpg_pkg::sat_coord(oy);
          end
          fpg_pkg::SHAPE_TRI:  begin x_reg <= fin.tx; y_reg <= fin.ty; end
          fpg_pkg::SHAPE_RECT: begin x_reg <= fin.rx; y_reg <= fin.ry; end
          default:             begin x_reg <= '0;     y_reg <= '0;     end
        endcase
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = {x_reg, y_reg, oor_reg};
endmodule

// File: design/fpg_checker.sv
// ---------------------------------------------------------------------------
// fpg_checker
// Port-level checks on the formation point generator.
// ---------------------------------------------------------------------------
`include "formation_point_generator_macros.svh"
module fpg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [34:0] out_data,
  input logic        pready
);
  `FPG_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data), "beat dropped")
  `FPG_ASSERT_NOW(a_oor_zero, out_valid && out_data[0], out_data[34:1] == 34'd0, "flag with data")
  `FPG_ASSERT_NOW(a_ready, !out_valid || out_ready, in_ready, "input stalled with free output")
  `FPG_ASSERT_NOW(a_pready, 1'b1, pready, "pready low")
endmodule

bind formation_point_generator fpg_checker u_fpg_checker (
  .clk, .rst,
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data (out_ch.data),
  .pready
);
